>>> hw/rtl/wlsr_pkg.sv
// Shared types, constants and helpers of the windowed latency statistics ring.
package wlsr_pkg;

    localparam int MAX_SLOTS_DEF = 64;

    localparam int TIME_W     = 32;
    localparam int LAT_W      = 32;
    localparam int SUM_W      = 64;
    localparam int SLOT_SEC_W = 16;
    localparam int ACT_W      = 7;
    localparam int AGE_W      = 6;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 192;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SECONDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS = 1'b1;

    localparam logic [SLOT_SEC_W-1:0] SLOT_SEC_RST = 16'd1;
    localparam logic [ACT_W-1:0]      ACT_RST      = 7'd64;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // The divider produces one quotient bit per cycle over a 64-bit dividend.
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [31:0]      stamp;
        logic [31:0]      count;
        logic [SUM_W-1:0] sum;
        logic [31:0]      min_lat;
        logic [31:0]      max_lat;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef enum logic [2:0] {
        DIV_NUM,
        DIV_POS,
        DIV_NPOS,
        DIV_RPOS,
        DIV_RATE,
        DIV_MEAN
    } div_sel_t;

    typedef enum logic [1:0] {
        WR_INIT,
        WR_WALK,
        WR_SAMPLE
    } wr_sel_t;

    typedef enum logic [1:0] {
        RES_REC,
        RES_DROP,
        RES_READ
    } res_kind_t;

    typedef struct packed {
        logic      load_in;
        logic      div_start;
        div_sel_t  div_sel;
        logic      mem_rd;
        logic      mem_wr;
        wr_sel_t   wr_sel;
        logic      clr_step;
        logic      base_from_rd;
        logic      base_clear;
        logic      walk_init;
        logic      walk_step;
        logic      upd_newest;
        logic      res_load;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic stamp_hit;
        logic too_old;
        logic walk_go;
        logic clr_last;
        logic cnt_zero;
    } dp_stat_t;

    function automatic slot_entry_t clear_entry(input logic [31:0] stamp);
        slot_entry_t e;
        e.stamp   = stamp;
        e.count   = '0;
        e.sum     = '0;
        e.min_lat = '1;
        e.max_lat = '0;
        return e;
    endfunction

endpackage

>>> hw/rtl/wlsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wlsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/wlsr_div.sv
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module wlsr_div
    import wlsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient,
    output logic [31:0] remainder
);

    logic [63:0]          dq_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [32:0] rem_sh;
    logic        ge;
    logic [31:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[63]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[62:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/wlsr_dp.sv
// Datapath: configuration, slot memory, divider, slot walk and result registers.
module wlsr_dp
    import wlsr_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  in_mode,
    input  logic [TIME_W-1:0]     in_time,
    input  logic [LAT_W-1:0]      in_latency,
    input  logic [AGE_W-1:0]      in_age,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  out_dropped,
    output logic [31:0]           out_stamp,
    output logic [31:0]           out_count,
    output logic [31:0]           out_rate,
    output logic [31:0]           out_mean,
    output logic [31:0]           out_min,
    output logic [31:0]           out_max
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (NW > ACT_W) ? NW : ACT_W;

    logic [SLOT_SEC_W-1:0] slot_sec_reg;
    logic [ACT_W-1:0]      active_reg;
    logic [31:0]           newest_reg;
    logic [AW-1:0]         clr_reg;

    logic                  mode_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [LAT_W-1:0]      lat_reg;
    logic [AGE_W-1:0]      age_reg;

    logic [31:0]           num_reg;
    logic [AW-1:0]         pos_reg;
    logic [AW-1:0]         npos_reg;
    logic [31:0]           stamp_reg;
    logic [31:0]           cur_reg;
    logic [AW-1:0]         p_reg;
    logic [31:0]           cstamp_reg;
    slot_entry_t           entry_reg;
    logic [31:0]           rate_reg;
    logic [31:0]           mean_reg;
    div_sel_t              div_sel_reg;

    logic                  dropped_reg;
    logic [31:0]           o_stamp_reg;
    logic [31:0]           o_count_reg;
    logic [31:0]           o_rate_reg;
    logic [31:0]           o_mean_reg;
    logic [31:0]           o_min_reg;
    logic [31:0]           o_max_reg;

    logic [SLOT_SEC_W-1:0] ss_eff;
    logic [CW-1:0]         act_ext;
    logic [CW-1:0]         n_c;
    logic [NW-1:0]         n_eff;
    logic [AW-1:0]         n_m1;
    logic [47:0]           prod;
    logic [31:0]           rp_sum;
    logic [AW-1:0]         p_dec;
    logic [AW-1:0]         pos_dec;

    logic [63:0]           div_dividend;
    logic [31:0]           div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [63:0]           div_q;
    logic [31:0]           div_r;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    slot_entry_t           ram_wdata;
    slot_entry_t           ram_rdata;
    logic [ENTRY_W-1:0]    ram_rdata_raw;

    slot_entry_t           sample_entry;
    logic                  sat;

    always_comb
    begin
        ss_eff  = (slot_sec_reg == '0) ? SLOT_SEC_W'(1) : slot_sec_reg;
        act_ext = CW'(active_reg);
        if (act_ext < CW'(2))
        begin
            n_c = CW'(2);
        end
        else if (act_ext > CW'(MAX_SLOTS))
        begin
            n_c = CW'(MAX_SLOTS);
        end
        else
        begin
            n_c = act_ext;
        end
        n_eff   = NW'(n_c);
        n_m1    = AW'(n_eff - NW'(1));
        prod    = {16'b0, num_reg} * {32'b0, ss_eff};
        rp_sum  = 32'(npos_reg) + 32'(age_reg) + 32'd1;
        p_dec   = (p_reg == '0) ? n_m1 : p_reg - AW'(1);
        pos_dec = (pos_reg == '0) ? n_m1 : pos_reg - AW'(1);
    end

    // Divider operands.
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_NUM:
            begin
                div_dividend = {32'b0, time_reg};
                div_divisor  = {16'b0, ss_eff};
            end
            DIV_POS:
            begin
                div_dividend = {32'b0, num_reg};
                div_divisor  = 32'(n_eff);
            end
            DIV_NPOS:
            begin
                div_dividend = {32'b0, newest_reg};
                div_divisor  = 32'(n_eff);
            end
            DIV_RPOS:
            begin
                div_dividend = {32'b0, rp_sum};
                div_divisor  = 32'(n_eff);
            end
            DIV_RATE:
            begin
                div_dividend = {32'b0, entry_reg.count};
                div_divisor  = {16'b0, ss_eff};
            end
            DIV_MEAN:
            begin
                div_dividend = entry_reg.sum;
                div_divisor  = entry_reg.count;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 32'd1;
            end
        endcase
    end

    wlsr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // A saturated count holds, together with its sum; min and max still move.
    always_comb
    begin
        sat                  = &entry_reg.count;
        sample_entry         = entry_reg;
        if (!sat)
        begin
            sample_entry.count = entry_reg.count + 32'd1;
            sample_entry.sum   = entry_reg.sum + SUM_W'(lat_reg);
        end
        if (lat_reg < entry_reg.min_lat)
        begin
            sample_entry.min_lat = lat_reg;
        end
        if (lat_reg > entry_reg.max_lat)
        begin
            sample_entry.max_lat = lat_reg;
        end
    end

    always_comb
    begin
        ram_we = cmd.mem_wr;
        unique case (cmd.wr_sel)
            WR_INIT:
            begin
                ram_waddr = clr_reg;
                ram_wdata = clear_entry(32'd0);
            end
            WR_WALK:
            begin
                ram_waddr = p_reg;
                ram_wdata = clear_entry(cstamp_reg);
            end
            WR_SAMPLE:
            begin
                ram_waddr = pos_reg;
                ram_wdata = sample_entry;
            end
            default:
            begin
                ram_waddr = pos_reg;
                ram_wdata = sample_entry;
            end
        endcase
    end

    wlsr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.mem_rd),
        .raddr (pos_reg),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = slot_entry_t'(ram_rdata_raw);

    // Control state: configuration, newest slot number and clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_sec_reg <= SLOT_SEC_RST;
            active_reg   <= ACT_RST;
            newest_reg   <= '0;
            clr_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_SLOT_SECONDS: slot_sec_reg <= cfg_wdata;
                    CFG_ACTIVE_SLOTS: active_reg   <= cfg_wdata[ACT_W-1:0];
                    default:          slot_sec_reg <= slot_sec_reg;
                endcase
            end
            if (cmd.upd_newest)
            begin
                newest_reg <= num_reg;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= in_mode;
            time_reg <= in_time;
            lat_reg  <= in_latency;
            age_reg  <= in_age;
        end
        if (cmd.div_start)
        begin
            div_sel_reg <= cmd.div_sel;
        end
        if (div_done)
        begin
            unique case (div_sel_reg)
                DIV_NUM:  num_reg  <= div_q[31:0];
                DIV_POS:  pos_reg  <= div_r[AW-1:0];
                DIV_NPOS: npos_reg <= div_r[AW-1:0];
                DIV_RPOS: pos_reg  <= div_r[AW-1:0];
                DIV_RATE: rate_reg <= div_q[31:0];
                DIV_MEAN: mean_reg <= div_q[31:0];
                default:  mean_reg <= div_q[31:0];
            endcase
        end
        if (cmd.mem_rd)
        begin
            stamp_reg <= prod[31:0];
        end
        if (cmd.base_from_rd)
        begin
            entry_reg <= ram_rdata;
        end
        else if (cmd.base_clear)
        begin
            entry_reg <= clear_entry(stamp_reg);
        end
        if (cmd.walk_init)
        begin
            cur_reg    <= num_reg - 32'd1;
            p_reg      <= pos_dec;
            cstamp_reg <= stamp_reg - 32'(ss_eff);
        end
        else if (cmd.walk_step)
        begin
            cur_reg    <= cur_reg - 32'd1;
            p_reg      <= p_dec;
            cstamp_reg <= cstamp_reg - 32'(ss_eff);
        end
        if (cmd.res_load)
        begin
            unique case (cmd.res_kind)
                RES_READ:
                begin
                    dropped_reg <= 1'b0;
                    o_stamp_reg <= entry_reg.stamp;
                    o_count_reg <= entry_reg.count;
                    o_rate_reg  <= rate_reg;
                    o_mean_reg  <= stat.cnt_zero ? 32'd0 : mean_reg;
                    o_min_reg   <= stat.cnt_zero ? 32'd0 : entry_reg.min_lat;
                    o_max_reg   <= entry_reg.max_lat;
                end
                default:
                begin
                    dropped_reg <= (cmd.res_kind == RES_DROP);
                    o_stamp_reg <= '0;
                    o_count_reg <= '0;
                    o_rate_reg  <= '0;
                    o_mean_reg  <= '0;
                    o_min_reg   <= '0;
                    o_max_reg   <= '0;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.div_busy  = div_busy;
        stat.div_done  = div_done;
        stat.stamp_hit = (ram_rdata.stamp == stamp_reg);
        stat.too_old   = (num_reg <= newest_reg);
        stat.walk_go   = (cur_reg > newest_reg) && (p_reg != pos_reg) && (mode_reg == MODE_RECORD);
        stat.clr_last  = (clr_reg == AW'(MAX_SLOTS - 1));
        stat.cnt_zero  = (entry_reg.count == '0);
    end

    assign out_dropped = dropped_reg;
    assign out_stamp   = o_stamp_reg;
    assign out_count   = o_count_reg;
    assign out_rate    = o_rate_reg;
    assign out_mean    = o_mean_reg;
    assign out_min     = o_min_reg;
    assign out_max     = o_max_reg;

endmodule

>>> hw/rtl/wlsr_ctrl.sv
// Controller: sequences the clearing pass, record and read items, and the result register.
module wlsr_ctrl
    import wlsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     in_mode,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_R_NUM,
        S_R_POS,
        S_R_RD,
        S_R_CHK,
        S_R_WALK,
        S_R_WR,
        S_Q_NPOS,
        S_Q_RPOS,
        S_Q_RD,
        S_Q_CAP,
        S_Q_RATE,
        S_Q_MEAN,
        S_DONE
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    logic      out_valid_reg;
    logic      new_slot_reg;
    logic      new_slot_next;
    res_kind_t kind_reg;
    res_kind_t kind_next;
    logic      div_idle;
    logic      res_take;

    assign div_idle = !stat.div_busy && !stat.div_done;
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd           = '0;
        cmd.div_sel   = DIV_NUM;
        cmd.wr_sel    = WR_SAMPLE;
        cmd.res_kind  = kind_reg;
        state_next    = state_reg;
        new_slot_next = new_slot_reg;
        kind_next     = kind_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_sel   = WR_INIT;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = (in_mode == MODE_READ) ? S_Q_NPOS : S_R_NUM;
                end
            end
            S_R_NUM:
            begin
                cmd.div_sel   = DIV_NUM;
                cmd.div_start = div_idle;
                if (stat.div_done)
                begin
                    state_next = S_R_POS;
                end
            end
            S_R_POS:
            begin
                cmd.div_sel   = DIV_POS;
                cmd.div_start = div_idle;
                if (stat.div_done)
                begin
                    state_next = S_R_RD;
                end
            end
            S_R_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_R_CHK;
            end
            S_R_CHK:
            begin
                if (stat.stamp_hit)
                begin
                    cmd.base_from_rd = 1'b1;
                    new_slot_next    = 1'b0;
                    state_next       = S_R_WR;
                end
                else if (stat.too_old)
                begin
                    kind_next  = RES_DROP;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.base_clear = 1'b1;
                    cmd.walk_init  = 1'b1;
                    new_slot_next  = 1'b1;
                    state_next     = S_R_WALK;
                end
            end
            S_R_WALK:
            begin
                if (stat.walk_go)
                begin
                    cmd.mem_wr    = 1'b1;
                    cmd.wr_sel    = WR_WALK;
                    cmd.walk_step = 1'b1;
                end
                else
                begin
                    state_next = S_R_WR;
                end
            end
            S_R_WR:
            begin
                cmd.mem_wr     = 1'b1;
                cmd.wr_sel     = WR_SAMPLE;
                cmd.upd_newest = new_slot_reg;
                kind_next      = RES_REC;
                state_next     = S_DONE;
            end
            S_Q_NPOS:
            begin
                cmd.div_sel   = DIV_NPOS;
                cmd.div_start = div_idle;
                if (stat.div_done)
                begin
                    state_next = S_Q_RPOS;
                end
            end
            S_Q_RPOS:
            begin
                cmd.div_sel   = DIV_RPOS;
                cmd.div_start = div_idle;
                if (stat.div_done)
                begin
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_Q_CAP;
            end
            S_Q_CAP:
            begin
                cmd.base_from_rd = 1'b1;
                state_next       = S_Q_RATE;
            end
            S_Q_RATE:
            begin
                cmd.div_sel   = DIV_RATE;
                cmd.div_start = div_idle;
                if (stat.div_done)
                begin
                    state_next = S_Q_MEAN;
                end
            end
            S_Q_MEAN:
            begin
                // An empty slot reports a zero mean, so the division is skipped.
                cmd.div_sel   = DIV_MEAN;
                cmd.div_start = div_idle && !stat.cnt_zero;
                kind_next     = RES_READ;
                if (stat.div_done || stat.cnt_zero)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            new_slot_reg  <= 1'b0;
            kind_reg      <= RES_REC;
        end
        else
        begin
            state_reg    <= state_next;
            new_slot_reg <= new_slot_next;
            kind_reg     <= kind_next;
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/windowed_latency_stats_ring_unit.sv
// Top level of the windowed latency statistics ring: ports, packing and checks.
//
// Input items arrive on the s_ stream. s_tuser selects the kind of item:
// 0 records one latency sample at a time in seconds, 1 reads one slot
// counted from the oldest. Every item gives exactly one result item on the
// m_ stream; m_tuser flags a record that was too old and was dropped.
// Configuration (slot length, active slot count) is written through the
// cfg_ channel, which is always ready; write it only while the block is idle.
// Items are handled one at a time. Each division runs on one shared
// bit-serial divider of 64 steps. A record item also clears each skipped
// slot on its way (fewer slots than are in use), and a read item skips the
// mean division when the slot is empty. After reset the slot memory is
// swept, one slot per cycle, over all MAX_SLOTS slots before the first
// item is accepted. A finished result waits in the output register; the
// block takes the next item meanwhile and holds its own next result until
// the receiver has taken the waiting one.
module windowed_latency_stats_ring_unit
    import wlsr_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // time_seconds [31:0], latency [63:32], age_index [69:64], zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode [0]
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // slot_stamp [31:0], sample_count [63:32], rate [95:64],
    // mean_latency [127:96], min_latency [159:128], max_latency [191:160]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // dropped [0]
    output logic [0:0]             m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        dropped;
    logic [31:0] o_stamp;
    logic [31:0] o_count;
    logic [31:0] o_rate;
    logic [31:0] o_mean;
    logic [31:0] o_min;
    logic [31:0] o_max;

    assign cfg_ready = 1'b1;

    wlsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser[0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    wlsr_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (s_tuser[0]),
        .in_time     (s_tdata[31:0]),
        .in_latency  (s_tdata[63:32]),
        .in_age      (s_tdata[69:64]),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_wdata   (cfg_data),
        .out_dropped (dropped),
        .out_stamp   (o_stamp),
        .out_count   (o_count),
        .out_rate    (o_rate),
        .out_mean    (o_mean),
        .out_min     (o_min),
        .out_max     (o_max)
    );

    assign m_tdata = {o_max, o_min, o_mean, o_rate, o_count, o_stamp};
    assign m_tuser = dropped;

    // Only one item is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in work");

    // The slot memory is written only by the clearing pass or an item in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> !s_tready)
        else $error("slot memory written while idle");

    // The divider is started only for an item in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (!s_tready && !stat.div_busy))
        else $error("divider started while idle or busy");

endmodule
